/* hdl/polymul_pkg.sv */
// Shared constants and field widths for the polynomial multiplier.
// No dependencies; imported by polynomial_multiplier_unit.
package polymul_pkg;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 5;
    localparam int POWER_W = 5;
    localparam int COEF_W  = 48;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int FRAC_W  = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MULTIPLY    = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

endpackage

/* hdl/polynomial_multiplier_unit.sv */
// Fixed-point polynomial multiplier: two coefficient stores and one shared
// multiply-accumulate pipeline driven by a small sequencer.
// Depends on polymul_pkg.
//
//   Channel  Handshake            Word contents
//   -------  -------------------  ------------------------------------------
//   input    in_valid / in_ready  cmd, index, value (Q16.16), last
//   output   out_valid/out_ready  power, coefficient (Q32.16, saturated),
//                                 final_res
//
// A multiply word walks every (i, j) pair of the two operands through one
// 32x32 multiplier, one pair per cycle while the output register can take a
// result; the pipeline then drains through the operand and product registers
// before the last result reaches the output register.
// Reset clears both stores and sets both lengths to one.
// When a result waits in the output register, the whole multiply pipeline
// holds until it is taken; in_ready stays low until the last result is formed.
module polynomial_multiplier_unit #(
    parameter int MAX_TERMS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [polymul_pkg::CMD_W-1:0]           cmd,
    input  logic [polymul_pkg::INDEX_W-1:0]         index,
    input  logic signed [polymul_pkg::VALUE_W-1:0]  value,
    input  logic                                    last,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [polymul_pkg::POWER_W-1:0]         power,
    output logic signed [polymul_pkg::COEF_W-1:0]   coefficient,
    output logic                                    final_res
);
    import polymul_pkg::*;

    localparam int AW    = $clog2(MAX_TERMS);
    // Each shifted product fits in COEF_W bits; the sum grows by log2 of the terms.
    localparam int ACC_W = COEF_W + AW + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Tag that travels with each product through the pipeline.
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic               final_term;
        logic [POWER_W-1:0] k;
    } tag_t;

    state_t state_reg, state_next;

    logic signed [VALUE_W-1:0] first_coefs_reg  [MAX_TERMS];
    logic signed [VALUE_W-1:0] second_coefs_reg [MAX_TERMS];
    logic [LEN_W-1:0] first_len_reg, first_len_next;
    logic [LEN_W-1:0] second_len_reg, second_len_next;

    logic [LEN_W-1:0] k_reg, k_next;
    logic [LEN_W-1:0] i_reg, i_next;

    tag_t s1_reg, s1_next;
    tag_t s2_reg, s2_next;

    logic signed [VALUE_W-1:0] op_a_reg, op_b_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic                      out_valid_reg, out_valid_next;
    logic [POWER_W-1:0]        power_reg, power_next;
    logic signed [COEF_W-1:0]  coef_reg, coef_next;
    logic                      final_reg, final_next;

    logic                      in_fire;
    logic                      load_ok;
    logic [AW-1:0]             wr_addr;
    logic                      adv;
    logic [LEN_W-1:0]          j_cur;
    logic [LEN_W-1:0]          i_hi;
    logic [LEN_W-1:0]          k_inc;
    logic [LEN_W-1:0]          i_lo_inc;
    logic [LEN_W-1:0]          k_top;
    logic                      issue_last;
    logic                      issue_final;
    logic                      issue_first;
    logic [LEN_W-1:0]          i_lo;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [COEF_W-1:0]  term;
    logic signed [ACC_W-1:0]   acc_base;
    logic                      sum_ovf;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign load_ok     = (int'(index) < MAX_TERMS);
    assign wr_addr     = AW'(index);
    assign out_valid   = out_valid_reg;
    assign power       = power_reg;
    assign coefficient = coef_reg;
    assign final_res   = final_reg;

    // The whole pipeline steps only when the output register can take a result.
    assign adv = !out_valid_reg || out_ready;

    // Pair selection for the product coefficient of power k:
    // i runs from max(0, k - len_second + 1) to min(k, len_first - 1).
    assign j_cur       = k_reg - i_reg;
    assign i_lo        = (k_reg >= second_len_reg) ? (k_reg - second_len_reg + 1'b1) : '0;
    assign i_hi        = (k_reg >= first_len_reg) ? (first_len_reg - 1'b1) : k_reg;
    assign k_inc       = k_reg + 1'b1;
    assign i_lo_inc    = (k_inc >= second_len_reg) ? (k_inc - second_len_reg + 1'b1) : '0;
    assign k_top       = first_len_reg + second_len_reg - 2'd2;
    assign issue_first = (i_reg == i_lo);
    assign issue_last  = (i_reg == i_hi);
    assign issue_final = issue_last && (k_reg == k_top);

    // Arithmetic: the product is shifted right by the fraction width with floor
    // rounding, then added to the running sum, which restarts on a new power.
    assign prod_next = op_a_reg * op_b_reg;
    assign term      = prod_reg[PROD_W-1:FRAC_W];
    assign acc_base  = s2_reg.first ? '0 : acc_reg;
    assign acc_next  = acc_base + ACC_W'(term);
    assign sum_ovf   = !((&acc_next[ACC_W-1:COEF_W-1]) || !(|acc_next[ACC_W-1:COEF_W-1]));

    always_comb
    begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        s1_next         = s1_reg;
        s2_next         = s2_reg;
        out_valid_next  = out_valid_reg;
        power_next      = power_reg;
        coef_next       = coef_reg;
        final_next      = final_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd == CMD_LOAD_FIRST && load_ok && last)
                    begin
                        first_len_next = LEN_W'(index) + 1'b1;
                    end
                    if (cmd == CMD_LOAD_SECOND && load_ok && last)
                    begin
                        second_len_next = LEN_W'(index) + 1'b1;
                    end
                    if (cmd == CMD_MULTIPLY)
                    begin
                        k_next     = '0;
                        i_next     = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (adv && issue_final)
                begin
                    state_next = ST_DRAIN;
                end
                else if (adv && issue_last)
                begin
                    k_next = k_inc;
                    i_next = i_lo_inc;
                end
                else if (adv)
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (adv && s2_reg.valid && s2_reg.final_term)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv)
        begin
            s1_next.valid      = (state_reg == ST_RUN);
            s1_next.first      = issue_first;
            s1_next.last       = issue_last;
            s1_next.final_term = issue_final;
            s1_next.k          = k_reg;
            s2_next            = s1_reg;
            if (s2_reg.valid && s2_reg.last)
            begin
                out_valid_next = 1'b1;
                power_next     = s2_reg.k;
                final_next     = s2_reg.final_term;
                if (sum_ovf)
                begin
                    coef_next = acc_next[ACC_W-1] ? COEF_MIN : COEF_MAX;
                end
                else
                begin
                    coef_next = acc_next[COEF_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= LEN_W'(1);
            second_len_reg <= LEN_W'(1);
            k_reg          <= '0;
            i_reg          <= '0;
            s1_reg         <= '0;
            s2_reg         <= '0;
            out_valid_reg  <= 1'b0;
            power_reg      <= '0;
            coef_reg       <= '0;
            final_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            s1_reg         <= s1_next;
            s2_reg         <= s2_next;
            out_valid_reg  <= out_valid_next;
            power_reg      <= power_next;
            coef_reg       <= coef_next;
            final_reg      <= final_next;
        end
    end

    // Coefficient stores, cleared at reset and written by load words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < MAX_TERMS; n++)
            begin
                first_coefs_reg[n]  <= '0;
                second_coefs_reg[n] <= '0;
            end
        end
        else if (in_fire && load_ok)
        begin
            if (cmd == CMD_LOAD_FIRST)
            begin
                first_coefs_reg[wr_addr] <= value;
            end
            if (cmd == CMD_LOAD_SECOND)
            begin
                second_coefs_reg[wr_addr] <= value;
            end
        end
    end

    // Datapath: operand fetch, multiply, accumulate, one register each.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_a_reg <= first_coefs_reg[i_reg[AW-1:0]];
            op_b_reg <= second_coefs_reg[j_cur[AW-1:0]];
            prod_reg <= prod_next;
            if (s2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // The sequencer only issues pairs inside both operands.
    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (i_reg < first_len_reg && j_cur < second_len_reg))
        else $error("issued coefficient pair lies outside an operand");

    // The product of highest power always closes its own sum.
    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_reg.valid && s2_reg.final_term) |-> s2_reg.last)
        else $error("final product term does not close its sum");

    // A held result freezes the running sum.
    a_hold_freezes_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(acc_reg))
        else $error("accumulator moved while a result was held");

    // Operand lengths stay between one and the store depth.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg != '0 && second_len_reg != '0
         && int'(first_len_reg) <= MAX_TERMS && int'(second_len_reg) <= MAX_TERMS))
        else $error("operand length out of range");

endmodule
